/* rtl/sga_pkg.sv */
// ----------------------------------------------------------------------------
// sga_pkg
// Shared widths, register codes, configuration struct and saturation helper
// for the sensor gain / moving average / low-pass block.
// ----------------------------------------------------------------------------
package sga_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned DATA_W      = 24;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned WLEN_W      = 6;
  localparam int unsigned ALPHA_W     = 15;
  localparam int unsigned BETA_W      = 16;
  localparam int unsigned CFG_AW      = 2;
  localparam int unsigned CFG_DW      = 16;

  localparam int unsigned WINDOW_MAX  = 32;
  localparam int unsigned WIN_AW      = $clog2(WINDOW_MAX);
  localparam int unsigned SUM_W       = DATA_W + WIN_AW;
  localparam int unsigned PROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned COEF_FRAC   = 15;
  localparam int unsigned SAT_W       = 48;

  typedef enum logic [CFG_AW-1:0] {
    CFG_GAIN  = 2'd0,
    CFG_WLEN  = 2'd1,
    CFG_ALPHA = 2'd2,
    CFG_BETA  = 2'd3
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0]         GAIN_RST  = 8'd2;
  localparam logic [WLEN_W-1:0]         WLEN_RST  = 6'd20;
  localparam logic [ALPHA_W-1:0]        ALPHA_RST = 15'd2979;
  localparam logic signed [BETA_W-1:0]  BETA_RST  = -16'sd26810;

  typedef struct packed {
    logic [GAIN_W-1:0]        gain;
    logic [WLEN_W-1:0]        wlen;
    logic [ALPHA_W-1:0]       alpha;
    logic signed [BETA_W-1:0] beta;
  } cfg_t;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  // Clamp a wide signed value to the data range.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] r;
    begin
      if (v > SAT_HI) begin
        r = SAT_HI;
      end else if (v < SAT_LO) begin
        r = SAT_LO;
      end else begin
        r = v;
      end
      return r[DATA_W-1:0];
    end
  endfunction

endpackage

/* rtl/sga_front.sv */
// ----------------------------------------------------------------------------
// sga_front
// Input stage: takes a sample request, multiplies it by the gain and hands
// the saturated scaled value to the queue.
// ----------------------------------------------------------------------------
module sga_front import sga_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [GAIN_W-1:0]          gain_i,
  output logic                       q_push_o,
  output logic signed [DATA_W-1:0]   q_data_o,
  input  logic                       q_full_i
);

  logic                      st_valid_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [GAIN_W:0]    gain_s;
  logic                      advance;
  logic                      accept;

  assign gain_s   = $signed({1'b0, gain_i});
  assign prod_d   = PROD_W'(sample_i) * PROD_W'(gain_s);
  assign advance  = st_valid_q && !q_full_i;
  assign full_o   = st_valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = advance;
  assign q_data_o = sat_data(SAT_W'(prod_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (accept) begin
      st_valid_q <= 1'b1;
    end else if (advance) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
    end
  end

endmodule

/* rtl/sga_queue.sv */
// ----------------------------------------------------------------------------
// sga_queue
// Short queue of scaled samples between the input stage and the averaging
// and filtering engine.
// ----------------------------------------------------------------------------
module sga_queue import sga_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic signed [DATA_W-1:0] data_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [DATA_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_q;
  logic [PTR_W-1:0]         rd_ptr_q;
  logic [CNT_W-1:0]         count_q;
  logic                     do_push;
  logic                     do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/sga_back.sv */
// ----------------------------------------------------------------------------
// sga_back
// Averaging and filtering engine: ring store with running sum, serial
// divide by the window length, Q15 first-order low-pass, result register.
// ----------------------------------------------------------------------------
module sga_back import sga_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     win_clear_i,
  input  logic                     q_empty_i,
  input  logic signed [DATA_W-1:0] q_data_i,
  output logic                     q_pop_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic signed [DATA_W-1:0] scaled_o,
  output logic signed [DATA_W-1:0] averaged_o,
  output logic signed [DATA_W-1:0] filtered_o
);

  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_CYCLES = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DVD_W      = DIV_CYCLES * DIV_BITS;
  localparam int unsigned CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int unsigned AB_W       = DATA_W + 1;
  localparam int unsigned P1_W       = ALPHA_W + 1 + AB_W;
  localparam int unsigned P2_W       = BETA_W + DATA_W;
  localparam int unsigned ACC_W      = P1_W + 1;
  localparam int unsigned QUO_W      = DVD_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_DIV, ST_AVG, ST_MUL, ST_ACC, ST_DONE
  } state_e;

  state_e                    state_q;
  logic signed [DATA_W-1:0]  mem_q [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]     valid_q;
  logic signed [DATA_W-1:0]  rd_data_q;
  logic                      rd_valid_q;
  logic [WIN_AW-1:0]         wr_slot_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [DATA_W-1:0]  x_q;
  logic [DVD_W-1:0]          dvd_q;
  logic [WIN_AW-1:0]         rem_q;
  logic                      neg_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [DATA_W-1:0]  avg_q;
  logic signed [DATA_W-1:0]  prev_avg_q;
  logic signed [DATA_W-1:0]  prev_filt_q;
  logic signed [P1_W-1:0]    p1_q;
  logic signed [P2_W-1:0]    p2_q;
  logic signed [DATA_W-1:0]  filt_q;
  logic                      out_valid_q;
  logic signed [DATA_W-1:0]  out_scaled_q;
  logic signed [DATA_W-1:0]  out_avg_q;
  logic signed [DATA_W-1:0]  out_filt_q;

  logic [WLEN_W-1:0]         len;
  logic [WIN_AW-1:0]         old_slot;
  logic signed [DATA_W-1:0]  old_val;
  logic signed [SUM_W-1:0]   sum_d;
  logic [SUM_W-1:0]          sum_mag;
  logic [DVD_W-1:0]          dvd_d;
  logic [WIN_AW-1:0]         rem_d;
  logic [WIN_AW:0]           trial;
  logic signed [QUO_W-1:0]   quo_s;
  logic signed [DATA_W-1:0]  avg_d;
  logic signed [AB_W-1:0]    ab_sum;
  logic signed [P1_W-1:0]    p1_d;
  logic signed [P2_W-1:0]    p2_d;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [DATA_W-1:0]  filt_d;

  always_comb begin
    if (cfg_i.wlen == '0) begin
      len = WLEN_W'(1);
    end else if (cfg_i.wlen > WLEN_W'(WINDOW_MAX)) begin
      len = WLEN_W'(WINDOW_MAX);
    end else begin
      len = cfg_i.wlen;
    end
  end

  assign old_slot = wr_slot_q - len[WIN_AW-1:0];
  assign old_val  = rd_valid_q ? rd_data_q : '0;
  assign sum_d    = sum_q - SUM_W'(old_val) + SUM_W'(x_q);
  assign sum_mag  = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);

  // Restoring division, DIV_BITS quotient bits per cycle.
  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_d, dvd_d[DVD_W-1]};
      dvd_d = {dvd_d[DVD_W-2:0], 1'b0};
      if (trial >= (WIN_AW + 1)'(len)) begin
        trial    = trial - (WIN_AW + 1)'(len);
        dvd_d[0] = 1'b1;
      end
      rem_d = trial[WIN_AW-1:0];
    end
  end

  assign quo_s  = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  assign avg_d  = sat_data(SAT_W'(quo_s));
  assign ab_sum = AB_W'(avg_q) + AB_W'(prev_avg_q);
  assign p1_d   = P1_W'($signed({1'b0, cfg_i.alpha})) * P1_W'(ab_sum);
  assign p2_d   = P2_W'(cfg_i.beta) * P2_W'(prev_filt_q);
  assign acc    = ACC_W'(p1_q) - ACC_W'(p2_q) + (ACC_W'(1) <<< (COEF_FRAC - 1));
  assign acc_sh = acc >>> COEF_FRAC;
  assign filt_d = sat_data(SAT_W'(acc_sh));

  assign q_pop_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign empty_o    = !out_valid_q;
  assign scaled_o   = out_scaled_q;
  assign averaged_o = out_avg_q;
  assign filtered_o = out_filt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      rd_valid_q   <= 1'b0;
      wr_slot_q    <= '0;
      sum_q        <= '0;
      x_q          <= '0;
      dvd_q        <= '0;
      rem_q        <= '0;
      neg_q        <= 1'b0;
      cnt_q        <= '0;
      avg_q        <= '0;
      prev_avg_q   <= '0;
      prev_filt_q  <= '0;
      p1_q         <= '0;
      p2_q         <= '0;
      filt_q       <= '0;
      out_valid_q  <= 1'b0;
      out_scaled_q <= '0;
      out_avg_q    <= '0;
      out_filt_q   <= '0;
    end else begin
      if (pop_i && out_valid_q && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (win_clear_i) begin
        valid_q   <= '0;
        wr_slot_q <= '0;
        sum_q     <= '0;
      end
      unique case (state_q)
        ST_IDLE: begin
          rd_valid_q <= valid_q[old_slot];
          if (!q_empty_i) begin
            x_q     <= q_data_i;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_q              <= sum_d;
          valid_q[wr_slot_q] <= 1'b1;
          wr_slot_q          <= wr_slot_q + WIN_AW'(1);
          dvd_q              <= DVD_W'(sum_mag);
          rem_q              <= '0;
          neg_q              <= sum_d[SUM_W-1];
          cnt_q              <= CNT_W'(DIV_CYCLES - 1);
          state_q            <= ST_DIV;
        end
        ST_DIV: begin
          dvd_q <= dvd_d;
          rem_q <= rem_d;
          if (cnt_q == '0) begin
            state_q <= ST_AVG;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_AVG: begin
          avg_q   <= avg_d;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          p1_q    <= p1_d;
          p2_q    <= p2_d;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          filt_q      <= filt_d;
          prev_avg_q  <= avg_q;
          prev_filt_q <= filt_d;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the result register is free or being drained.
          if (!out_valid_q || pop_i) begin
            out_valid_q  <= 1'b1;
            out_scaled_q <= x_q;
            out_avg_q    <= avg_q;
            out_filt_q   <= filt_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      rd_data_q <= mem_q[old_slot];
    end
    if (state_q == ST_SUM) begin
      mem_q[wr_slot_q] <= x_q;
    end
  end

endmodule

/* rtl/sensor_gain_average_lowpass.sv */
// ----------------------------------------------------------------------------
// sensor_gain_average_lowpass
// Gain, moving average and first-order low-pass over a sensor sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive sample_i with push_i high; the request is
//   taken at a clock edge where full_o is low. Result side is a queue too:
//   scaled_o, averaged_o and filtered_o hold the oldest result while
//   empty_o is low; pop_i at such an edge takes it.
//   Configuration is a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i):
//   0 gain, 1 window length, 2 alpha (Q15), 3 beta (Q15, signed). Write only
//   while no request is in flight. A window length write restarts the
//   average from zero history.
//   The engine works on one request at a time and takes the next from the
//   queue only once the last has left for the output register; its steps
//   are the store access, the serial divide by the window length (2
//   quotient bits per cycle), the multiply and the accumulate.
//   A stalled result side holds the finished result in the output register;
//   up to four more requests are taken (one finished in the engine, two in
//   the queue, one in the input stage) before full_o rises.
//   Reset clears all state and restores the register defaults
//   (gain 2, window 20, alpha 2979, beta -26810).
// ----------------------------------------------------------------------------
module sensor_gain_average_lowpass import sga_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic signed [DATA_W-1:0]   scaled_o,
  output logic signed [DATA_W-1:0]   averaged_o,
  output logic signed [DATA_W-1:0]   filtered_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_AW-1:0]          cfg_addr_i,
  input  logic [CFG_DW-1:0]          cfg_wdata_i
);

  cfg_t                     cfg_q;
  logic                     win_clear;
  logic                     q_push;
  logic signed [DATA_W-1:0] q_wdata;
  logic                     q_full;
  logic                     q_pop;
  logic signed [DATA_W-1:0] q_rdata;
  logic                     q_empty;

  assign win_clear = cfg_we_i && (cfg_idx_e'(cfg_addr_i) == CFG_WLEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain  <= GAIN_RST;
      cfg_q.wlen  <= WLEN_RST;
      cfg_q.alpha <= ALPHA_RST;
      cfg_q.beta  <= BETA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_GAIN:  cfg_q.gain  <= cfg_wdata_i[GAIN_W-1:0];
        CFG_WLEN:  cfg_q.wlen  <= cfg_wdata_i[WLEN_W-1:0];
        CFG_ALPHA: cfg_q.alpha <= cfg_wdata_i[ALPHA_W-1:0];
        CFG_BETA:  cfg_q.beta  <= $signed(cfg_wdata_i[BETA_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  sga_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .sample_i (sample_i),
    .gain_i   (cfg_q.gain),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  sga_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  sga_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .win_clear_i (win_clear),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .scaled_o    (scaled_o),
    .averaged_o  (averaged_o),
    .filtered_o  (filtered_o)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gain / moving average / low-pass block. Sends
// signed samples through the push/full side, predicts scaled, averaged and
// filtered values in a local model of the chain, and checks each popped
// result in order. Covers register extremes, window clamping and restart,
// filter saturation, a long output stall, and random register phases with
// random gaps on both sides in most phases.
// ----------------------------------------------------------------------------
module tb_top;
  import sga_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned RAND_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS    = 115;
  localparam int unsigned PRINT_CAP      = 100;
  localparam longint      OUT_HI         = 64'sd8388607;
  localparam longint      OUT_LO         = -64'sd8388608;

  typedef struct {
    logic signed [DATA_W-1:0] scaled;
    logic signed [DATA_W-1:0] averaged;
    logic signed [DATA_W-1:0] filtered;
  } chain_out_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       push_i;
  logic                       full_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       empty_o;
  logic                       pop_i;
  logic signed [DATA_W-1:0]   scaled_o;
  logic signed [DATA_W-1:0]   averaged_o;
  logic signed [DATA_W-1:0]   filtered_o;
  logic                       cfg_we_i;
  logic [CFG_AW-1:0]          cfg_addr_i;
  logic [CFG_DW-1:0]          cfg_wdata_i;

  // Local copy of the chain: registers and filter/window state
  logic [GAIN_W-1:0]          gain_r;
  logic [WLEN_W-1:0]          wlen_r;
  logic [ALPHA_W-1:0]         alpha_r;
  logic signed [BETA_W-1:0]   beta_r;
  longint                     win_hist [WINDOW_MAX];
  int unsigned                wr_slot;
  longint                     hist_sum;
  longint                     prev_avg;
  longint                     prev_filt;

  chain_out_t                 chain_expect_q[$];
  int unsigned                mismatch_count;
  int unsigned                cycle_count;
  logic                       tx_active;
  logic                       tx_gaps_on;
  logic                       rx_gaps_on;
  int unsigned                hold_seq;

  sensor_gain_average_lowpass u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .sample_i   (sample_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .scaled_o   (scaled_o),
    .averaged_o (averaged_o),
    .filtered_o (filtered_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sensor_gain_average_lowpass test failed");
      $finish;
    end
  end

  function automatic longint clamp24(input longint v);
    if (v > OUT_HI) return OUT_HI;
    if (v < OUT_LO) return OUT_LO;
    return v;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic clear_window_model();
    for (int i = 0; i < WINDOW_MAX; i++) win_hist[i] = 0;
    wr_slot  = 0;
    hist_sum = 0;
  endtask

  task automatic reset_chain_model();
    gain_r    = GAIN_RST;
    wlen_r    = WLEN_RST;
    alpha_r   = ALPHA_RST;
    beta_r    = BETA_RST;
    prev_avg  = 0;
    prev_filt = 0;
    clear_window_model();
  endtask

  // Advance the chain model by one sample and queue the expected result
  task automatic predict_chain_step(input logic signed [SAMPLE_W-1:0] s);
    int unsigned len;
    int unsigned old_slot;
    longint      sc;
    longint      avg;
    longint      acc;
    longint      filt;
    chain_out_t  res;
    sc = clamp24(longint'(s) * longint'(gain_r));
    if (wlen_r == '0) len = 1;
    else if (32'(wlen_r) > WINDOW_MAX) len = WINDOW_MAX;
    else len = 32'(wlen_r);
    old_slot = (wr_slot + WINDOW_MAX - len) % WINDOW_MAX;
    hist_sum = hist_sum - win_hist[old_slot] + sc;
    win_hist[wr_slot] = sc;
    wr_slot = (wr_slot + 1) % WINDOW_MAX;
    avg  = clamp24(hist_sum / longint'(len));
    acc  = longint'(alpha_r) * (avg + prev_avg) - longint'(beta_r) * prev_filt;
    filt = clamp24((acc + 64'sd16384) >>> COEF_FRAC);
    prev_avg  = avg;
    prev_filt = filt;
    res.scaled   = sc[DATA_W-1:0];
    res.averaged = avg[DATA_W-1:0];
    res.filtered = filt[DATA_W-1:0];
    chain_expect_q.insert(chain_expect_q.size(), res);
  endtask

  // Lower push only if it is up, so it sees one update per edge
  task automatic tx_release();
    if (tx_active) begin
      push_i    <= 1'b0;
      tx_active  = 1'b0;
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int unsigned gap;
    push_i    <= 1'b1;
    sample_i  <= s;
    tx_active  = 1'b1;
    do @(posedge clk_i); while (full_o);
    predict_chain_step(s);
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      tx_release();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    tx_release();
    while (chain_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_GAIN:  gain_r = val[GAIN_W-1:0];
      CFG_WLEN: begin
        wlen_r = val[WLEN_W-1:0];
        clear_window_model();
      end
      CFG_ALPHA: alpha_r = val[ALPHA_W-1:0];
      CFG_BETA:  beta_r = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int unsigned r;
    logic signed [SAMPLE_W-1:0] s;
    r = $urandom_range(0, 9);
    if (r == 0) s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    else if (r == 1) s = SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
    else s = SAMPLE_W'($urandom);
    return s;
  endfunction

  // Result side: random idling plus a long hold when requested
  initial begin : rx_drive
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned gap_left;
    hold_seen = 0;
    hold_left = 0;
    gap_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop_i <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        pop_i <= 1'b0;
        gap_left--;
      end else begin
        pop_i <= 1'b1;
        if (rx_gaps_on) gap_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    chain_out_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (chain_expect_q.size() == 0) begin
        report_mismatch("result with no request pending", scaled_o, 0);
      end else begin
        want = chain_expect_q.pop_front();
        if (scaled_o !== want.scaled)
          report_mismatch("scaled", scaled_o, want.scaled);
        if (averaged_o !== want.averaged)
          report_mismatch("averaged", averaged_o, want.averaged);
        if (filtered_o !== want.filtered)
          report_mismatch("filtered", filtered_o, want.filtered);
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
  endtask

  // Zero length acts as one, lengths above the store act as the store size
  task automatic test_window_bounds();
    write_reg(CFG_WLEN, 16'd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0064);
    write_reg(CFG_WLEN, 16'd63);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    write_reg(CFG_WLEN, 16'd33);
    send_sample(16'sh1234);
    send_sample(16'shedcb);
  endtask

  task automatic test_filter_saturation();
    write_reg(CFG_GAIN, 16'd255);
    write_reg(CFG_WLEN, 16'd1);
    write_reg(CFG_ALPHA, 16'd32767);
    write_reg(CFG_BETA, 16'h8000);
    repeat (4) send_sample(16'sh7fff);
    repeat (3) send_sample(16'sh8000);
    write_reg(CFG_GAIN, 16'd0);
    write_reg(CFG_ALPHA, 16'd0);
    write_reg(CFG_BETA, 16'h7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // Hold the result side so the block fills and stalls its input
  task automatic test_output_stall();
    write_reg(CFG_GAIN, 16'd3);
    write_reg(CFG_WLEN, 16'd8);
    write_reg(CFG_ALPHA, 16'd2979);
    write_reg(CFG_BETA, 16'h97c6);
    tx_gaps_on = 1'b0;
    hold_seq++;
    repeat (40) send_sample(rand_sample());
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [CFG_DW-1:0] w;
    for (int p = 0; p < RAND_PHASES; p++) begin
      w = CFG_DW'($urandom);
      if ($urandom_range(0, 3) == 0) w[GAIN_W-1:0] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      write_reg(CFG_GAIN, w);
      // keep the window across some phases
      if ($urandom_range(0, 2) != 0) begin
        w = CFG_DW'($urandom);
        if ($urandom_range(0, 4) == 0) w[WLEN_W-1:0] = WLEN_W'($urandom_range(0, 63));
        else w[WLEN_W-1:0] = WLEN_W'($urandom_range(1, WINDOW_MAX));
        write_reg(CFG_WLEN, w);
      end
      w = CFG_DW'($urandom);
      if ($urandom_range(0, 3) == 0) w[ALPHA_W-1:0] = $urandom_range(0, 1) ? 15'h7fff : 15'h0;
      write_reg(CFG_ALPHA, w);
      w = CFG_DW'($urandom);
      if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      else if ($urandom_range(0, 1) == 0) w = 16'h8000 | 16'($urandom_range(0, 32767));
      write_reg(CFG_BETA, w);
      tx_gaps_on = (p % 4 != 3);
      rx_gaps_on = (p % 4 != 3);
      repeat (PHASE_ITEMS) send_sample(rand_sample());
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    push_i      <= 1'b0;
    pop_i       <= 1'b0;
    sample_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= CFG_GAIN;
    cfg_wdata_i <= '0;
    tx_active      = 1'b0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    hold_seq       = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    reset_chain_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_window_bounds();
    test_filter_saturation();
    test_output_stall();
    test_random_phases();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (chain_expect_q.size() != 0)
      report_mismatch("results still pending", chain_expect_q.size(), 0);
    if (mismatch_count == 0) begin
      $display("sensor_gain_average_lowpass test passed");
    end else begin
      $display("sensor_gain_average_lowpass test failed");
    end
    $finish;
  end

endmodule
